@@ sv/dtp_pkg.sv @@
package dtp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int CNT_W     = 12;
  localparam int NUM_W     = 36;
  localparam int STEP_W    = 6;
  localparam int QUEUE_LEN = 2;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ENDIAN = 3'd2;
  localparam logic [2:0] REG_FX     = 3'd3;
  localparam logic [2:0] REG_FY     = 3'd4;
  localparam logic [2:0] REG_CX     = 3'd5;
  localparam logic [2:0] REG_CY     = 3'd6;

  typedef struct packed {
    logic [CNT_W-1:0] u;
    logic [CNT_W-1:0] v;
    logic [15:0]      z;
    logic             fe;
  } pixel_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
  } optics_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

endpackage

@@ sv/dtp_front.sv @@
module dtp_front
  import dtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       first_byte,
  input  logic [7:0]       second_byte,
  input  logic             big_endian,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output pixel_t           pix
);

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic             row_end;
  logic             frame_end;

  // classify the pixel position
  always_comb begin
    row_end   = ({1'b0, col} + DIM_W'(1)) >= clamp_dim(image_width);
    frame_end = row_end && (({1'b0, row} + DIM_W'(1)) >= clamp_dim(image_height));
    pix.u  = col;
    pix.v  = row;
    pix.z  = big_endian ? {first_byte, second_byte} : {second_byte, first_byte};
    pix.fe = frame_end;
  end

  // advance raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/dtp_queue.sv @@
module dtp_queue
  import dtp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  pixel_t wr_data,
  input  logic   rd,
  output pixel_t rd_data,
  output logic   full,
  output logic   empty
);

  pixel_t      slots [QUEUE_LEN];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full    = count == 2'(QUEUE_LEN);
  assign empty   = count == '0;
  assign rd_data = slots[rptr];

  // store items and track fill
  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wr_data;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

@@ sv/dtp_back.sv @@
module dtp_back
  import dtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  pixel_t             q_data,
  output logic               q_rd,
  input  optics_t            optics,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [15:0]        point_z,
  output logic               frame_end
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [15:0]      rem;
    logic [NUM_W-1:0] dvd;
  } div_t;

  state_t            state;
  logic [15:0]       mag_x, mag_y, z, fx, fy;
  logic              neg_x, neg_y, zero_x, zero_y, fe;
  div_t              dx, dy;
  logic [STEP_W-1:0] step;
  logic              out_valid;
  logic signed [17:0] diff_x, diff_y;
  logic              load;

  function automatic div_t div_step(input div_t d, input logic [15:0] f);
    logic [16:0] trial;
    div_t        r;
    trial = {d.rem, d.dvd[NUM_W-1]};
    r.dvd = {d.dvd[NUM_W-2:0], 1'b0};
    r.rem = trial[15:0];
    if (trial >= {1'b0, f}) begin
      r.rem = 16'(trial - {1'b0, f});
      r.dvd[0] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] saturate(input logic [NUM_W-1:0] q, input logic neg,
                                           input logic zero);
    if (zero) return '0;
    if (!neg) return (q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    return (q > NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : 32'(-q[31:0]);
  endfunction

  assign diff_x = $signed({2'b00, q_data.u, 4'b0000}) - $signed({2'b00, optics.cx});
  assign diff_y = $signed({2'b00, q_data.v, 4'b0000}) - $signed({2'b00, optics.cy});
  assign q_rd   = (state == S_IDLE) && !q_empty;
  assign load   = (state == S_DONE) && (!out_valid || pop);
  assign empty  = !out_valid;

  // sequence: fetch, multiply, divide, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (!q_empty) state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  if (step == STEP_W'(NUM_W - 1)) state <= S_DONE;
        S_DONE: if (load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      // fill the output on load, drop it when popped
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end

    case (state)
      S_IDLE: begin
        neg_x <= diff_x[17];
        neg_y <= diff_y[17];
        mag_x <= diff_x[17] ? 16'(-diff_x) : diff_x[15:0];
        mag_y <= diff_y[17] ? 16'(-diff_y) : diff_y[15:0];
        z     <= q_data.z;
        fe    <= q_data.fe;
        fx    <= optics.fx;
        fy    <= optics.fy;
      end
      S_MUL: begin
        dx.dvd <= {32'(mag_x) * 32'(z), 4'b0000};
        dy.dvd <= {32'(mag_y) * 32'(z), 4'b0000};
        dx.rem <= '0;
        dy.rem <= '0;
        zero_x <= (mag_x == '0) || (z == '0);
        zero_y <= (mag_y == '0) || (z == '0);
        step   <= '0;
      end
      S_DIV: begin
        dx   <= div_step(dx, fx);
        dy   <= div_step(dy, fy);
        step <= step + STEP_W'(1);
      end
      default: ;
    endcase

    if (load) begin
      point_x   <= saturate(dx.dvd, neg_x, zero_x);
      point_y   <= saturate(dy.dvd, neg_y, zero_y);
      point_z   <= z;
      frame_end <= fe;
    end
  end

endmodule

@@ sv/depth_to_point_backprojection_top.sv @@
// From push to result: fetch, multiply, 36 divide steps, output.
// The back end works on one item at a time; its rate is set by the bit-serial restoring divider.
// The input queue takes two items ahead while the divider works.
// Reset: synchronous, active high; clears counters, queue, output flag, registers to defaults.
module depth_to_point_backprojection_top
  import dtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         first_byte,
  input  logic [7:0]         second_byte,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [15:0]        point_z,
  output logic               frame_end,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [DIM_W-1:0] image_width, image_height;
  logic             big_endian;
  optics_t          optics;
  pixel_t           pix, q_data;
  logic             take, q_rd, q_empty;

  assign take = push && !full;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      big_endian   <= 1'b0;
      optics.fx    <= 16'd8192;
      optics.fy    <= 16'd8192;
      optics.cx    <= 16'd5120;
      optics.cy    <= 16'd3840;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_ENDIAN: big_endian   <= cfg_data[0];
        REG_FX:     optics.fx    <= cfg_data;
        REG_FY:     optics.fy    <= cfg_data;
        REG_CX:     optics.cx    <= cfg_data;
        REG_CY:     optics.cy    <= cfg_data;
        default: ;
      endcase
    end
  end

  dtp_front u_front (
    .clk, .rst, .take, .first_byte, .second_byte, .big_endian,
    .image_width, .image_height, .pix
  );

  dtp_queue u_queue (
    .clk, .rst, .wr(take), .wr_data(pix), .rd(q_rd), .rd_data(q_data),
    .full, .empty(q_empty)
  );

  dtp_back u_back (
    .clk, .rst, .q_empty, .q_data, .q_rd, .optics, .pop, .empty,
    .point_x, .point_y, .point_z, .frame_end
  );

endmodule
